FILE: rtl/core/chqm_pkg.sv
// Shared constants, types and codes for the cell heap queue manager.
package chqm_pkg;

	localparam int CELL_COUNT = 1024;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int WORD_BITS  = 16;
	localparam int IO_BITS    = 16;
	localparam int CNT_W      = 11;
	localparam int TOP_W      = ADDR_W + 1;

	localparam logic [ADDR_W-1:0] NIL_ADDR   = ADDR_W'(2);
	localparam logic [ADDR_W-1:0] UNDEF_ADDR = ADDR_W'(3);
	localparam logic [ADDR_W-1:0] EVENT_RST  = ADDR_W'(5);
	localparam logic [TOP_W-1:0]  HEAP_RST   = TOP_W'(28);
	localparam logic [TOP_W-1:0]  HEAP_END   = TOP_W'(CELL_COUNT);
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
	localparam logic [WORD_BITS-1:0] FREE_TYPE = WORD_BITS'(-9);

	localparam int F_TYPE = 0;
	localparam int F_HEAD = 1;
	localparam int F_TAIL = 2;
	localparam int F_LINK = 3;

	typedef logic [3:0][WORD_BITS-1:0] cell_t;

	typedef enum logic [2:0] {
		FN_ALLOC = 3'd0,
		FN_FREE  = 3'd1,
		FN_READ  = 3'd2,
		FN_WRITE = 3'd3,
		FN_PUT   = 3'd4,
		FN_POP   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_DFREE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic              rd;
		logic [3:0]        we;
		logic [ADDR_W-1:0] addr;
		cell_t             wdata;
	} mem_req_t;

endpackage

FILE: rtl/core/chqm_cell_ram.sv
// Cell store: synchronous RAM with per-word write enables and a registered read.
module chqm_cell_ram
	import chqm_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output cell_t    rdata
);

	cell_t mem_q [CELL_COUNT];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (req.we[i]) begin
				mem_q[req.addr][i] <= req.wdata[i];
			end
		end
		if (req.rd) begin
			rdata <= mem_q[req.addr];
		end
	end

endmodule

FILE: rtl/core/chqm_ctrl.sv
// Sequencer: list and queue pointers, read-modify-write of the cell store.
module chqm_ctrl
	import chqm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           func,
	input  logic [ADDR_W-1:0]    cell_addr,
	input  logic                 queue_sel,
	input  logic [3:0]           field_mask,
	input  logic signed [IO_BITS-1:0] new_type,
	input  logic signed [IO_BITS-1:0] new_head,
	input  logic signed [IO_BITS-1:0] new_tail,
	input  logic signed [IO_BITS-1:0] new_link,
	input  cell_t                rdata,
	output mem_req_t             req,
	output logic                 busy,
	output logic                 done,
	output status_t              status_o,
	output logic [ADDR_W-1:0]    raddr_o,
	output logic [3:0][IO_BITS-1:0] rdw_o,
	output logic [CNT_W-1:0]     free_count_o
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t              state_q, state_d;
	func_t               op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                qsel_q;
	cell_t               words_q;
	logic [ADDR_W-1:0]   free_head_q, free_head_d;
	logic [TOP_W-1:0]    heap_top_q, heap_top_d;
	logic [CNT_W-1:0]    free_cells_q, free_cells_d;
	logic [ADDR_W-1:0]   qhead_q [2];
	logic [ADDR_W-1:0]   qtail_q [2];
	logic [ADDR_W-1:0]   qh_new, qt_new;
	logic                q_wr, q_idx;
	logic                done_q, done_d;
	status_t             status_q, status_d;
	logic [ADDR_W-1:0]   raddr_q, raddr_d;
	logic [3:0][IO_BITS-1:0] rdw_q, rdw_d;
	cell_t               in_words;
	logic                accept;
	logic [ADDR_W-1:0]   rd_link;

	assign accept = start && (state_q == S_IDLE);
	assign rd_link = rdata[F_LINK][ADDR_W-1:0];

	assign in_words[F_TYPE] = WORD_BITS'(new_type);
	assign in_words[F_HEAD] = WORD_BITS'(new_head);
	assign in_words[F_TAIL] = WORD_BITS'(new_tail);
	assign in_words[F_LINK] = WORD_BITS'(new_link);

	always_comb begin
		state_d      = state_q;
		free_head_d  = free_head_q;
		heap_top_d   = heap_top_q;
		free_cells_d = free_cells_q;
		q_wr         = 1'b0;
		q_idx        = qsel_q;
		qh_new       = qhead_q[qsel_q];
		qt_new       = qtail_q[qsel_q];
		req          = '0;
		done_d       = 1'b0;
		status_d     = ST_OK;
		raddr_d      = '0;
		rdw_d        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req.addr = cell_addr;
					unique case (func_t'(func))
						FN_ALLOC: begin
							if (free_head_q != NIL_ADDR) begin
								req.rd   = 1'b1;
								req.addr = free_head_q;
								state_d  = S_EXEC;
							end else if (heap_top_q < HEAP_END) begin
								req.we     = 4'hF;
								req.addr   = heap_top_q[ADDR_W-1:0];
								req.wdata  = in_words;
								heap_top_d = heap_top_q + TOP_W'(1);
								raddr_d    = heap_top_q[ADDR_W-1:0];
								done_d     = 1'b1;
							end else begin
								status_d = ST_OOM;
								raddr_d  = UNDEF_ADDR;
								done_d   = 1'b1;
							end
						end
						FN_FREE, FN_READ: begin
							req.rd  = 1'b1;
							state_d = S_EXEC;
						end
						FN_WRITE: begin
							req.we    = field_mask;
							req.wdata = in_words;
							done_d    = 1'b1;
						end
						FN_PUT: begin
							req.we[F_LINK]    = 1'b1;
							req.wdata[F_LINK] = WORD_BITS'(NIL_ADDR);
							state_d           = S_EXEC;
						end
						FN_POP: begin
							if (qhead_q[queue_sel] == NIL_ADDR) begin
								status_d = ST_EMPTY;
								raddr_d  = UNDEF_ADDR;
								done_d   = 1'b1;
							end else begin
								req.rd   = 1'b1;
								req.addr = qhead_q[queue_sel];
								state_d  = S_EXEC;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				req.addr = addr_q;
				unique case (op_q)
					FN_ALLOC: begin
						req.we      = 4'hF;
						req.addr    = free_head_q;
						req.wdata   = words_q;
						raddr_d     = free_head_q;
						free_head_d = rd_link;
						if (free_cells_q != '0) begin
							free_cells_d = free_cells_q - CNT_W'(1);
						end
					end
					FN_FREE: begin
						if (rdata[F_TYPE] == FREE_TYPE) begin
							status_d = ST_DFREE;
						end else begin
							req.we            = 4'hF;
							req.wdata[F_TYPE] = FREE_TYPE;
							req.wdata[F_HEAD] = WORD_BITS'(UNDEF_ADDR);
							req.wdata[F_TAIL] = WORD_BITS'(UNDEF_ADDR);
							req.wdata[F_LINK] = WORD_BITS'(free_head_q);
							free_head_d       = addr_q;
							if (free_cells_q != CNT_MAX) begin
								free_cells_d = free_cells_q + CNT_W'(1);
							end
						end
					end
					FN_READ: begin
						for (int i = 0; i < 4; i++) begin
							rdw_d[i] = rdata[i][IO_BITS-1:0];
						end
					end
					FN_PUT: begin
						q_wr   = 1'b1;
						qt_new = addr_q;
						if (qhead_q[qsel_q] == NIL_ADDR) begin
							qh_new = addr_q;
						end else begin
							req.we[F_LINK]    = 1'b1;
							req.addr          = qtail_q[qsel_q];
							req.wdata[F_LINK] = WORD_BITS'(addr_q);
						end
					end
					FN_POP: begin
						q_wr              = 1'b1;
						qh_new            = rd_link;
						req.we[F_LINK]    = 1'b1;
						req.addr          = qhead_q[qsel_q];
						req.wdata[F_LINK] = WORD_BITS'(NIL_ADDR);
						raddr_d           = qhead_q[qsel_q];
						if (rd_link == NIL_ADDR) begin
							qt_new = NIL_ADDR;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_head_q  <= NIL_ADDR;
			heap_top_q   <= HEAP_RST;
			free_cells_q <= '0;
			qhead_q[0]   <= EVENT_RST;
			qtail_q[0]   <= EVENT_RST;
			qhead_q[1]   <= NIL_ADDR;
			qtail_q[1]   <= NIL_ADDR;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			free_head_q  <= free_head_d;
			heap_top_q   <= heap_top_d;
			free_cells_q <= free_cells_d;
			done_q       <= done_d;
			if (q_wr) begin
				qhead_q[q_idx] <= qh_new;
				qtail_q[q_idx] <= qt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		raddr_q  <= raddr_d;
		rdw_q    <= rdw_d;
		if (accept) begin
			op_q    <= func_t'(func);
			addr_q  <= cell_addr;
			qsel_q  <= queue_sel;
			words_q <= in_words;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status_o     = status_q;
	assign raddr_o      = raddr_q;
	assign rdw_o        = rdw_q;
	assign free_count_o = free_cells_q;

endmodule

FILE: rtl/core/cell_heap_queue_manager_top.sv
// Top level of the cell heap queue manager: sequencer plus cell store.
//
// Command channel: drive func and its operands with start high; the word is
// taken at a rising edge where start is high and busy is low. busy is high
// while an operation holds the cell store.
// Result channel: done is high for exactly one cycle with status,
// result_addr, read_* and free_count; the receiver cannot stall it.
// Timing: write, alloc from the heap top, out-of-memory, empty pop and
// unknown codes finish from idle (done the cycle after acceptance,
// busy stays low). Alloc from the free list, free, read, put and pop take
// a RAM read (or first write) step and then a write-back step, set by the
// single-port cell RAM with its registered read. A new command may be taken
// in the cycle that done is shown.
// Throughput: one command per cycle while no write-back step holds busy.
// Reset (arst_n low): free list empty, heap top 28, free count 0, event
// queue holds cell 5, continuation queue empty. Cell contents are not
// cleared; the host loads cells before they are read.
module cell_heap_queue_manager_top
	import chqm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                func,
	input  logic [ADDR_W-1:0]         cell_addr,
	input  logic                      queue_sel,
	input  logic [3:0]                field_mask,
	input  logic signed [IO_BITS-1:0] new_type,
	input  logic signed [IO_BITS-1:0] new_head,
	input  logic signed [IO_BITS-1:0] new_tail,
	input  logic signed [IO_BITS-1:0] new_link,
	output logic                      done,
	output logic [1:0]                status,
	output logic [ADDR_W-1:0]         result_addr,
	output logic signed [IO_BITS-1:0] read_type,
	output logic signed [IO_BITS-1:0] read_head,
	output logic signed [IO_BITS-1:0] read_tail,
	output logic signed [IO_BITS-1:0] read_link,
	output logic [CNT_W-1:0]          free_count
);

	mem_req_t                req;
	cell_t                   rdata;
	status_t                 status_w;
	logic [3:0][IO_BITS-1:0] rdw;

	chqm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.cell_addr    (cell_addr),
		.queue_sel    (queue_sel),
		.field_mask   (field_mask),
		.new_type     (new_type),
		.new_head     (new_head),
		.new_tail     (new_tail),
		.new_link     (new_link),
		.rdata        (rdata),
		.req          (req),
		.busy         (busy),
		.done         (done),
		.status_o     (status_w),
		.raddr_o      (result_addr),
		.rdw_o        (rdw),
		.free_count_o (free_count)
	);

	chqm_cell_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign status    = status_w;
	assign read_type = rdw[F_TYPE];
	assign read_head = rdw[F_HEAD];
	assign read_tail = rdw[F_TAIL];
	assign read_link = rdw[F_LINK];

endmodule

FILE: rtl/core/chqm_checker.sv
// Port-level checker for the cell heap queue manager, bound to the top level.
module chqm_checker
	import chqm_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [1:0]                status,
	input logic [ADDR_W-1:0]         result_addr,
	input logic [CNT_W-1:0]          free_count
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither in progress nor done");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("operation exceeded two cycles");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_empty_undef: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY || status == ST_OOM) |-> result_addr == UNDEF_ADDR)
		else $error("failed alloc or pop without undefined address");

	a_count_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_count) |-> done)
		else $error("free count changed without a result");

endmodule

bind cell_heap_queue_manager_top chqm_checker u_chqm_checker (.*);
